/* hw/rtl/sme_pkg.sv */
//------------------------------------------------------------------------------
// sme_pkg
// types, codes and sizes shared by the stack machine executor
//------------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        CMD_PUSH = 4'd0,
        CMD_ADD  = 4'd1,
        CMD_SUB  = 4'd2,
        CMD_MUL  = 4'd3,
        CMD_DIV  = 4'd4,
        CMD_POW  = 4'd5,
        CMD_MOD  = 4'd6,
        CMD_SQRT = 4'd7,
        CMD_OUT  = 4'd8,
        CMD_HALT = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_DIVZ    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_UNDER   = 3'd4,
        ST_OVER    = 3'd5,
        ST_SQRT    = 3'd6,
        ST_IGNORED = 3'd7
    } status_t;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] immediate;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               out_valid;
        logic signed [31:0] out_value;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD0,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_DIVFIX,
        S_POW,
        S_POWSQ,
        S_SQRT,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/stack_machine_executor_unit.sv */
//------------------------------------------------------------------------------
// stack_machine_executor_unit
// stack machine executor for 32-bit signed integers, one instruction per item
//------------------------------------------------------------------------------
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid / in_stall
// res     | output    | out_item_t | res_valid / res_stall
//
// push, add, sub and pow with a negative exponent: read, decide, write
// out, halt, ignored and error items: read, decide; mul adds a multiply
// div and mod: 32 restoring steps on the shared 33-bit adder, after operand
// reads from the single-port stack memory, then sign fix and write
// sqrt produces one result bit per step; pow uses square-and-multiply,
// one multiply per cycle
// reset empties the stack and clears the stop flag; stack words are not cleared
// a stalled result holds the unit; the next instruction is taken the cycle after
// it leaves
//------------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor_unit
    import sme_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_data
);

    // stack memory, single port, registered read
    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we;
    logic [PTR_W-1:0] mem_addr;
    logic [31:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    state_t state_reg, state_next;

    logic [LVL_W-1:0] level_reg, level_next;
    logic             stopped_reg, stopped_next;
    in_item_t         item_reg, item_next;
    logic [31:0]      a_reg, a_next;    // left operand / accumulator
    logic [31:0]      b_reg, b_next;    // right operand / base
    logic [31:0]      q_reg, q_next;    // quotient / exponent / sqrt result
    logic [31:0]      r_reg, r_next;    // remainder / sqrt remainder
    logic [5:0]       cnt_reg, cnt_next;
    out_item_t        res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    // shared adder
    logic [32:0] add_a, add_b, add_sum;
    logic        add_sub;
    assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

    logic [31:0] mul_p;
    logic [31:0] mul_x, mul_y;
    assign mul_p = mul_x * mul_y;

    logic [31:0] mag_a, mag_b;
    assign mag_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;

    logic two_op;
    always_comb
    begin
        two_op = 1'b0;
        case (item_reg.command)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW, CMD_MOD: two_op = 1'b1;
            default: two_op = 1'b0;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE) || res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            stopped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            stopped_reg   <= stopped_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:    state_next = S_RD0;
            S_RD0:    state_next = S_DECIDE;
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (!stopped_reg)
                begin
                    if (item_reg.command == CMD_PUSH && level_reg < LVL_W'(STACK_DEPTH))
                        state_next = S_WRITE;
                    else if (two_op && level_reg >= LVL_W'(2))
                    begin
                        case (item_reg.command)
                            CMD_ADD, CMD_SUB: state_next = S_WRITE;
                            CMD_MUL:          state_next = S_MUL;
                            CMD_DIV, CMD_MOD:
                                state_next = (b_reg == 32'd0) ? S_DONE : S_DIV;
                            default:
                                state_next = b_reg[31] ?
                                             ((rd_data_reg == 32'd0) ? S_DONE : S_WRITE)
                                             : S_POW;
                        endcase
                    end
                    else if (item_reg.command == CMD_SQRT && level_reg != '0
                             && !b_reg[31])
                        state_next = S_SQRT;
                end
            end
            S_MUL:    state_next = S_WRITE;
            S_DIV:    state_next = (cnt_reg == 6'd31) ? S_DIVFIX : S_DIV;
            S_DIVFIX: state_next = S_WRITE;
            S_POW:    state_next = (q_reg == 32'd0) ? S_WRITE : S_POWSQ;
            S_POWSQ:  state_next = S_POW;
            S_SQRT:   state_next = (cnt_reg == 6'd15) ? S_WRITE : S_SQRT;
            S_WRITE:  state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next      = item_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        level_next     = level_reg;
        stopped_next   = stopped_reg;
        mem_we         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = a_reg;
        add_a          = '0;
        add_b          = '0;
        add_sub        = 1'b0;
        mul_x          = a_reg;
        mul_y          = b_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // result register holds until a new transaction is taken
                if (in_valid && !in_stall)
                begin
                    item_next = in_data;
                    res_next  = '{status: ST_OK, out_valid: 1'b0, out_value: '0};
                    cnt_next  = '0;
                end
            end
            S_RD1:
            begin
                mem_addr = PTR_W'(level_reg - LVL_W'(1));
            end
            S_RD0:
            begin
                mem_addr = PTR_W'(level_reg - LVL_W'(2));
                b_next   = rd_data_reg;   // top of stack
            end
            S_DECIDE:
            begin
                a_next = rd_data_reg;
                if (stopped_reg)
                    res_next.status = ST_IGNORED;
                else
                begin
                    case (item_reg.command)
                        CMD_PUSH:
                        begin
                            if (level_reg >= LVL_W'(STACK_DEPTH))
                                res_next.status = ST_OVER;
                            else
                                a_next = item_reg.immediate;
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW, CMD_MOD:
                        begin
                            if (level_reg < LVL_W'(2))
                                res_next.status = ST_UNDER;
                            else
                            begin
                                case (item_reg.command)
                                    CMD_ADD:
                                    begin
                                        add_a  = {1'b0, rd_data_reg};
                                        add_b  = {1'b0, b_reg};
                                        a_next = add_sum[31:0];
                                    end
                                    CMD_SUB:
                                    begin
                                        add_a   = {1'b0, rd_data_reg};
                                        add_b   = {1'b0, b_reg};
                                        add_sub = 1'b1;
                                        a_next  = add_sum[31:0];
                                    end
                                    CMD_DIV, CMD_MOD:
                                    begin
                                        if (b_reg == 32'd0)
                                            res_next.status = ST_DIVZ;
                                        r_next = '0;
                                    end
                                    CMD_POW:
                                    begin
                                        if (b_reg[31])
                                        begin
                                            if (rd_data_reg == 32'd0)
                                                res_next.status = ST_DIVZ;
                                            else if (rd_data_reg == 32'd1)
                                                a_next = 32'd1;
                                            else if (rd_data_reg == 32'hFFFF_FFFF)
                                                a_next = b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                                            else
                                                a_next = 32'd0;
                                        end
                                        else
                                        begin
                                            q_next = b_reg;       // exponent
                                            b_next = rd_data_reg; // base
                                            a_next = 32'd1;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        CMD_SQRT:
                        begin
                            if (level_reg == '0)
                                res_next.status = ST_UNDER;
                            else if (b_reg[31])
                                res_next.status = ST_SQRT;
                            else
                            begin
                                r_next = b_reg;   // remaining value
                                q_next = '0;      // result
                                a_next = 32'h4000_0000;
                            end
                        end
                        CMD_OUT:
                        begin
                            if (level_reg == '0)
                                res_next.status = ST_UNDER;
                            else
                            begin
                                res_next.out_valid = 1'b1;
                                res_next.out_value = b_reg;
                                level_next = level_reg - LVL_W'(1);
                            end
                        end
                        CMD_HALT: res_next.status = ST_HALT;
                        default:  res_next.status = ST_UNKNOWN;
                    endcase
                end
            end
            S_MUL:
            begin
                mul_x  = a_reg;
                mul_y  = b_reg;
                a_next = mul_p;
            end
            S_DIV:
            begin
                // restoring division on magnitudes, quotient bits in q_reg
                add_a   = {r_reg, mag_a[5'd31 - cnt_reg[4:0]]};
                add_b   = {1'b0, mag_b};
                add_sub = 1'b1;
                if (!add_sum[32])
                begin
                    r_next = add_sum[31:0];
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = add_a[31:0];
                    q_next = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
            end
            S_DIVFIX:
            begin
                if (item_reg.command == CMD_DIV)
                    a_next = (a_reg[31] != b_reg[31]) ? (32'd0 - q_reg) : q_reg;
                else
                    a_next = a_reg[31] ? (32'd0 - r_reg) : r_reg;
            end
            S_POW:
            begin
                if (q_reg[0])
                begin
                    mul_x  = a_reg;
                    mul_y  = b_reg;
                    a_next = mul_p;
                end
            end
            S_POWSQ:
            begin
                mul_x  = b_reg;
                mul_y  = b_reg;
                b_next = mul_p;
                q_next = {1'b0, q_reg[31:1]};
            end
            S_SQRT:
            begin
                // a_reg holds the probe bit, q_reg the result, r_reg the rest
                add_a   = {1'b0, r_reg};
                add_b   = {1'b0, q_reg} + {1'b0, a_reg};
                add_sub = 1'b1;
                if (!add_sum[32])
                begin
                    r_next = add_sum[31:0];
                    q_next = {1'b0, q_reg[31:1]} + a_reg;
                end
                else
                    q_next = {1'b0, q_reg[31:1]};
                a_next   = {2'b00, a_reg[31:2]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                    a_next = (!add_sum[32]) ? ({1'b0, q_reg[31:1]} + a_reg)
                                            : {1'b0, q_reg[31:1]};
            end
            S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = a_reg;
                if (item_reg.command == CMD_PUSH)
                begin
                    mem_addr   = PTR_W'(level_reg);
                    level_next = level_reg + LVL_W'(1);
                end
                else if (item_reg.command == CMD_SQRT)
                    mem_addr = PTR_W'(level_reg - LVL_W'(1));
                else
                begin
                    mem_addr   = PTR_W'(level_reg - LVL_W'(2));
                    level_next = level_reg - LVL_W'(1);
                end
            end
            S_DONE:
            begin
                if (res_reg.status != ST_OK && res_reg.status != ST_IGNORED)
                    stopped_next = 1'b1;
                if (item_reg.last_item)
                begin
                    level_next   = '0;
                    stopped_next = 1'b0;
                end
                res_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* verif/tb_stack_machine_executor_unit.sv */
//------------------------------------------------------------------------------
// tb_stack_machine_executor_unit
// drives short programs and random instructions into the executor and checks
// every result against a cycle-free model of the stack, kept in step with the
// accepted instructions
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stack_machine_executor_unit;
    import sme_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_data;

    stack_machine_executor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    in_item_t    program_q[$];
    out_item_t   predicted_q[$];
    logic [31:0] stack_mem[STACK_DEPTH];
    int          stack_lvl    = 0;
    logic        stopped_flag = 1'b0;
    int          fail_count   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    bit          stimulus_done = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] int_root(logic [31:0] x);
        logic [31:0] r;
        logic [31:0] b;
        r = '0;
        b = 32'h4000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] e);
        logic [31:0] acc;
        logic [31:0] bb;
        acc = 32'd1;
        bb  = base;
        for (int i = 0; i < 32; i++)
        begin
            if (e[i])
                acc = acc * bb;
            bb = bb * bb;
        end
        return acc;
    endfunction

    // two-operand arithmetic; a is the deeper value
    function automatic logic [2:0] arith(logic [3:0] cmd, logic [31:0] a,
                                         logic [31:0] b, output logic [31:0] r);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        r  = '0;
        case (cmd)
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_MUL: r = a * b;
            CMD_DIV:
            begin
                if (b == 0)
                    return ST_DIVZ;
                q = ua / ub;
                r = (a[31] != b[31]) ? -q : q;
            end
            CMD_MOD:
            begin
                if (b == 0)
                    return ST_DIVZ;
                q = ua % ub;
                r = a[31] ? -q : q;
            end
            default:
            begin
                if (b[31])
                begin
                    if (a == 0)
                        return ST_DIVZ;
                    if (a == 32'd1)
                        r = 32'd1;
                    else if (a == 32'hFFFF_FFFF)
                        r = b[0] ? 32'hFFFF_FFFF : 32'd1;
                    else
                        r = '0;
                end
                else
                    r = int_power(a, b);
            end
        endcase
        return ST_OK;
    endfunction

    function automatic out_item_t execute_instr(in_item_t it);
        out_item_t   o;
        logic [31:0] r;
        o = '0;
        o.status = ST_OK;
        if (stopped_flag)
            o.status = ST_IGNORED;
        else
        begin
            case (it.command)
                CMD_PUSH:
                    if (stack_lvl >= STACK_DEPTH)
                        o.status = ST_OVER;
                    else
                    begin
                        stack_mem[stack_lvl] = it.immediate;
                        stack_lvl++;
                    end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW, CMD_MOD:
                    if (stack_lvl < 2)
                        o.status = ST_UNDER;
                    else
                    begin
                        o.status = arith(it.command, stack_mem[stack_lvl-2],
                                         stack_mem[stack_lvl-1], r);
                        if (o.status == ST_OK)
                        begin
                            stack_mem[stack_lvl-2] = r;
                            stack_lvl--;
                        end
                    end
                CMD_SQRT, CMD_OUT:
                    if (stack_lvl < 1)
                        o.status = ST_UNDER;
                    else if (it.command == CMD_OUT)
                    begin
                        o.out_valid = 1'b1;
                        o.out_value = stack_mem[stack_lvl-1];
                        stack_lvl--;
                    end
                    else if (stack_mem[stack_lvl-1][31])
                        o.status = ST_SQRT;
                    else
                        stack_mem[stack_lvl-1] = int_root(stack_mem[stack_lvl-1]);
                CMD_HALT: o.status = ST_HALT;
                default:  o.status = ST_UNKNOWN;
            endcase
        end
        if (o.status != ST_OK && o.status != ST_IGNORED)
            stopped_flag = 1'b1;
        if (it.last_item)
        begin
            stack_lvl    = 0;
            stopped_flag = 1'b0;
        end
        return o;
    endfunction

    task automatic add_instr(logic [3:0] cmd, logic [31:0] imm, logic last);
        in_item_t it;
        it.command   = cmd;
        it.immediate = imm;
        it.last_item = last;
        program_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 6))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'($urandom_range(0, 2)) - 32'd1;
            3:       return $urandom;
            default: return 32'($urandom_range(0, 40)) - 32'd20;
        endcase
    endfunction

    // program with random content, closed by a last item; some overflow the stack
    task automatic add_program(output int n);
        int depth;
        int ops;
        logic [3:0] op;
        depth = 0;
        n     = 0;
        ops   = $urandom_range(1, 12);
        if ($urandom_range(0, 40) == 0)
            ops = STACK_DEPTH + 3;
        for (int i = 0; i < ops; i++)
        begin
            if (ops > STACK_DEPTH)
            begin
                add_instr(CMD_PUSH, $urandom, 1'b0);
                n++;
                continue;
            end
            if (depth < 2 || $urandom_range(0, 3) == 0)
            begin
                add_instr(CMD_PUSH, rand_value(), 1'b0);
                depth++;
                n++;
            end
            case ($urandom_range(0, 8))
                0: op = CMD_ADD;
                1: op = CMD_SUB;
                2: op = CMD_MUL;
                3: op = CMD_DIV;
                4: op = CMD_MOD;
                5: op = CMD_POW;
                6: op = CMD_SQRT;
                7: op = CMD_OUT;
                default: op = CMD_PUSH;
            endcase
            if (op == CMD_POW)
            begin
                add_instr(CMD_PUSH, ($urandom_range(0, 7) == 0) ? $urandom :
                          32'($urandom_range(0, 40)) - 32'd8, 1'b0);
                add_instr(CMD_POW, $urandom, 1'b0);
                n += 2;
            end
            else if (op == CMD_SQRT && $urandom_range(0, 1))
            begin
                add_instr(CMD_PUSH, {1'b0, 31'($urandom)}, 1'b0);
                add_instr(CMD_SQRT, $urandom, 1'b0);
                depth++;
                n += 2;
            end
            else
            begin
                add_instr(op, (op == CMD_PUSH) ? rand_value() : $urandom, 1'b0);
                n++;
                if (op == CMD_PUSH)
                    depth++;
                else if (op == CMD_OUT || op != CMD_SQRT)
                    depth--;
            end
            if ($urandom_range(0, 30) == 0)
            begin
                add_instr(CMD_HALT, $urandom, 1'b0);
                n++;
            end
        end
        add_instr(CMD_OUT, $urandom, 1'b1);
        n++;
    endtask

    initial
    begin
        int total;
        int n;
        // wrap, most negative by minus one, zero divisors, pow and sqrt cases
        add_instr(CMD_PUSH, 32'h7FFF_FFFF, 1'b0);
        add_instr(CMD_PUSH, 32'd1, 1'b0);
        add_instr(CMD_ADD, 32'hFFFF_FFFF, 1'b0);
        add_instr(CMD_PUSH, 32'h8000_0000, 1'b0);
        add_instr(CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
        add_instr(CMD_DIV, '0, 1'b0);
        add_instr(CMD_PUSH, 32'h8000_0000, 1'b0);
        add_instr(CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
        add_instr(CMD_MOD, '0, 1'b0);
        add_instr(CMD_OUT, '0, 1'b0);
        add_instr(CMD_OUT, '0, 1'b0);
        add_instr(CMD_OUT, '0, 1'b0);
        add_instr(CMD_PUSH, 32'd5, 1'b0);
        add_instr(CMD_PUSH, 32'd0, 1'b0);
        add_instr(CMD_MOD, '0, 1'b0);
        add_instr(CMD_PUSH, 32'd3, 1'b0);
        add_instr(CMD_HALT, '0, 1'b1);
        add_instr(CMD_PUSH, 32'd0, 1'b0);
        add_instr(CMD_PUSH, 32'hFFFF_FFFD, 1'b0);
        add_instr(CMD_POW, '0, 1'b1);
        add_instr(CMD_PUSH, 32'hFFFF_FFFC, 1'b0);
        add_instr(CMD_SQRT, '0, 1'b1);
        add_instr(CMD_ADD, '0, 1'b1);
        add_instr(4'd15, 32'hFFFF_FFFF, 1'b1);
        add_instr(CMD_HALT, '0, 1'b0);
        add_instr(CMD_SUB, '0, 1'b1);
        total = program_q.size();
        while (total < 1450)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_instr(4'($urandom), $urandom, $urandom_range(0, 9) == 0);
                total++;
            end
            else
            begin
                add_program(n);
                total += n;
            end
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts with gaps, one pause until all results are back
    int burst_left = 0;
    int gap_left   = 0;
    int sent_count = 0;
    bit pause_done = 1'b0;

    always @(posedge clk)
    begin
        logic     nxt_valid;
        in_item_t nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted_q.push_back(execute_instr(in_data));
                sent_count++;
                nxt_valid = 1'b0;
            end
            if (!(in_valid && in_stall))
            begin
                if (sent_count == 900 && !pause_done)
                begin
                    nxt_valid = 1'b0;
                    if (predicted_q.size() == 0)
                        pause_done = 1'b1;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    nxt_valid = 1'b0;
                end
                else if (program_q.size() > 0)
                begin
                    nxt_data  = program_q.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                    end
                    burst_left--;
                end
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // receiver: random stall modes, one long hold-off
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 500)
        begin
            hold_done = 1'b1;
            hold_left = 400;
            res_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(1, 64);
            end
            else
                mode_left--;
            res_stall <= (stall_mode == 0) ? 1'b0 :
                         (stall_mode == 1) ? 1'($urandom_range(0, 1)) :
                         ($urandom_range(0, 4) != 0);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (predicted_q.size() == 0)
            begin
                $display("%0t unexpected result: actual %p", $time, res_data);
                fail_count++;
            end
            else
            begin
                want = predicted_q.pop_front();
                if (res_data.status !== want.status)
                begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, want.status, res_data.status);
                    fail_count++;
                end
                if (res_data.out_valid !== want.out_valid)
                begin
                    $display("%0t out_valid: expected %0b actual %0b",
                             $time, want.out_valid, res_data.out_valid);
                    fail_count++;
                end
                if (res_data.out_value !== want.out_value)
                begin
                    $display("%0t out_value: expected %0d actual %0d",
                             $time, want.out_value, res_data.out_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_stack_machine_executor_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (program_q.size() != 0 || in_valid || predicted_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && predicted_q.size() == 0)
            $display("tb_stack_machine_executor_unit: PASS");
        else
        begin
            if (predicted_q.size() != 0)
                $display("%0t %0d results never arrived", $time, predicted_q.size());
            $display("tb_stack_machine_executor_unit: FAIL");
        end
        $finish;
    end

endmodule

/* stack_machine_executor_unit.f */
hw/rtl/sme_pkg.sv
hw/rtl/stack_machine_executor_unit.sv
verif/tb_stack_machine_executor_unit.sv
